// ----- design/frustum_aabb_cull_defines.svh -----
// Assertion macros used by the checker file of the culling block.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef FRUSTUM_AABB_CULL_DEFINES_SVH
`define FRUSTUM_AABB_CULL_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FAC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/fac_pkg.sv -----
package fac_pkg;

    localparam int PLANES      = 4;
    localparam int AXES        = 3;
    localparam int NORMAL_W    = 14;
    localparam int NORMAL_PK_W = NORMAL_W * AXES;
    localparam int COORD_W     = 24;
    localparam int DIST_W      = 48;
    localparam int PROD_W      = NORMAL_W + COORD_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int TOTAL_W     = DIST_W + 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = DIST_W;
    localparam int IN_TDATA_W  = COORD_W * AXES * 2;
    localparam int OUT_TDATA_W = 8;

    typedef logic signed [COORD_W-1:0]  t_coord;
    typedef logic signed [NORMAL_W-1:0] t_ncomp;
    typedef logic [NORMAL_PK_W-1:0]     t_normal;
    typedef logic signed [DIST_W-1:0]   t_dist;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic signed [TOTAL_W-1:0]  t_total;

    typedef enum logic [1:0] {
        VERDICT_OUTSIDE    = 2'd0,
        VERDICT_INTERSECTS = 2'd1,
        VERDICT_INSIDE     = 2'd2
    } t_verdict;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_NORMAL     = 3'd0,
        CFG_RIGHT_NORMAL    = 3'd1,
        CFG_TOP_NORMAL      = 3'd2,
        CFG_BOTTOM_NORMAL   = 3'd3,
        CFG_LEFT_DISTANCE   = 3'd4,
        CFG_RIGHT_DISTANCE  = 3'd5,
        CFG_TOP_DISTANCE    = 3'd6,
        CFG_BOTTOM_DISTANCE = 3'd7
    } t_cfg_idx;

    // Box corners, axis 0 is x.
    typedef struct packed {
        t_coord [AXES-1:0] hi;
        t_coord [AXES-1:0] lo;
    } t_box;

    // Load enables of the three pipeline stages inside a plane unit.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

    // Per-plane outcome: outside, or touching (far corner on or behind the plane).
    typedef struct packed {
        logic outside;
        logic touch;
    } t_plane_flags;

    // Reset normals, packed z,y,x from the top bit down.
    localparam t_normal LEFT_NORMAL_RST   = {14'sd3276, 14'sd0, -14'sd2457};
    localparam t_normal RIGHT_NORMAL_RST  = {14'sd3276, 14'sd0, 14'sd2457};
    localparam t_normal TOP_NORMAL_RST    = {14'sd2896, -14'sd2896, 14'sd0};
    localparam t_normal BOTTOM_NORMAL_RST = {14'sd2896, 14'sd2896, 14'sd0};

endpackage

// ----- design/fac_plane.sv -----
module fac_plane (
    input  logic                  i_clk,
    input  fac_pkg::t_stage_en    i_en,
    input  fac_pkg::t_normal      i_normal,
    input  fac_pkg::t_dist        i_distance,
    input  fac_pkg::t_box         i_box,
    output fac_pkg::t_plane_flags o_flags
);
    import fac_pkg::*;

    // Stage 1: per-axis products for the near (p) and far (n) corners.
    t_prod [AXES-1:0] r_prod_p, n_prod_p;
    t_prod [AXES-1:0] r_prod_n, n_prod_n;
    // Stage 2: sums of the three products.
    t_sum             r_sum_p, n_sum_p;
    t_sum             r_sum_n, n_sum_n;
    // Stage 3: distance added and sign tested.
    t_plane_flags     r_flags, n_flags;

    always_comb begin
        t_ncomp comp;
        t_coord p_sel;
        t_coord n_sel;
        for (int a = 0; a < AXES; a++) begin
            comp = t_ncomp'(i_normal[a*NORMAL_W +: NORMAL_W]);
            // A positive component pulls the max bound toward the plane side.
            if (!comp[NORMAL_W-1] && (comp != '0)) begin
                p_sel = i_box.hi[a];
                n_sel = i_box.lo[a];
            end else begin
                p_sel = i_box.lo[a];
                n_sel = i_box.hi[a];
            end
            n_prod_p[a] = t_prod'(comp) * t_prod'(p_sel);
            n_prod_n[a] = t_prod'(comp) * t_prod'(n_sel);
        end
    end

    always_comb begin
        n_sum_p = t_sum'(r_prod_p[0]) + t_sum'(r_prod_p[1]) + t_sum'(r_prod_p[2]);
        n_sum_n = t_sum'(r_prod_n[0]) + t_sum'(r_prod_n[1]) + t_sum'(r_prod_n[2]);
    end

    always_comb begin
        t_total tot_p;
        t_total tot_n;
        tot_p = t_total'(r_sum_p) + t_total'(i_distance);
        tot_n = t_total'(r_sum_n) + t_total'(i_distance);
        n_flags.outside = tot_p[TOTAL_W-1];
        n_flags.touch   = tot_n[TOTAL_W-1] || (tot_n == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_prod_p <= n_prod_p;
            r_prod_n <= n_prod_n;
        end
        if (i_en.s2) begin
            r_sum_p <= n_sum_p;
            r_sum_n <= n_sum_n;
        end
        if (i_en.s3) begin
            r_flags <= n_flags;
        end
    end

    assign o_flags = r_flags;

endmodule

// ----- design/frustum_aabb_cull.sv -----
// Channel   | Direction | Content
// s_axis    | in        | one box: min_x, min_y, min_z, max_x, max_y, max_z (24 bits each)
// m_axis    | out       | one verdict per box: 0 outside, 1 intersects, 2 inside
// i_cfg     | in        | plane normals (index 0..3) and distances (index 4..7)
//
// One box is accepted per cycle while s_axis_tready is high. Each box moves in order
// through the four register stages that lead to its verdict: multiply, product sum,
// distance add and sign test, verdict register.
// Reset is synchronous and active low; it empties the pipeline and loads the
// default planes. A stall on m_axis holds the verdict register, and earlier
// stages keep filling their empty slots before s_axis_tready drops.
module frustum_aabb_cull (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [fac_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fac_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Box requests.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0 up: min_x, min_y, min_z, max_x, max_y, max_z.
    input  logic [fac_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Verdicts.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Fields from bit 0 up: verdict (2 bits), then zero fill.
    output logic [fac_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import fac_pkg::*;

    // Plane registers, in the order left, right, top, bottom.
    t_normal [PLANES-1:0] r_normal;
    t_dist   [PLANES-1:0] r_distance;

    // Valid bits travel alongside the plane unit stages.
    logic r_v1, r_v2, r_v3;
    logic r_out_valid;
    t_verdict r_verdict, n_verdict;

    t_stage_en                 stage_en;
    logic                      out_ready;
    t_box                      box;
    t_plane_flags [PLANES-1:0] flags;

    // Configuration writes. Normals use the low bits of the write data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal[0]   <= LEFT_NORMAL_RST;
            r_normal[1]   <= RIGHT_NORMAL_RST;
            r_normal[2]   <= TOP_NORMAL_RST;
            r_normal[3]   <= BOTTOM_NORMAL_RST;
            r_distance    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEFT_NORMAL:     r_normal[0]   <= i_cfg_data[NORMAL_PK_W-1:0];
                CFG_RIGHT_NORMAL:    r_normal[1]   <= i_cfg_data[NORMAL_PK_W-1:0];
                CFG_TOP_NORMAL:      r_normal[2]   <= i_cfg_data[NORMAL_PK_W-1:0];
                CFG_BOTTOM_NORMAL:   r_normal[3]   <= i_cfg_data[NORMAL_PK_W-1:0];
                CFG_LEFT_DISTANCE:   r_distance[0] <= t_dist'(i_cfg_data);
                CFG_RIGHT_DISTANCE:  r_distance[1] <= t_dist'(i_cfg_data);
                CFG_TOP_DISTANCE:    r_distance[2] <= t_dist'(i_cfg_data);
                CFG_BOTTOM_DISTANCE: r_distance[3] <= t_dist'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Each stage loads when it is empty or its content moves on, so bubbles
    // are squeezed out even while the output is stalled.
    assign out_ready     = !r_out_valid || m_axis_tready;
    assign stage_en.s3   = !r_v3 || out_ready;
    assign stage_en.s2   = !r_v2 || stage_en.s3;
    assign stage_en.s1   = !r_v1 || stage_en.s2;
    assign s_axis_tready = stage_en.s1;

    // Unpack the request: lower corner first, x in the lowest bits.
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            box.lo[a] = s_axis_tdata[a*COORD_W +: COORD_W];
            box.hi[a] = s_axis_tdata[(a+AXES)*COORD_W +: COORD_W];
        end
    end

    for (genvar p = 0; p < PLANES; p++) begin : g_plane
        fac_plane u_plane (
            .i_clk      (i_clk),
            .i_en       (stage_en),
            .i_normal   (r_normal[p]),
            .i_distance (r_distance[p]),
            .i_box      (box),
            .o_flags    (flags[p])
        );
    end

    // Outside on any plane wins; otherwise any touching plane makes it an
    // intersection; otherwise the box is fully inside.
    always_comb begin
        logic any_out;
        logic any_touch;
        any_out   = 1'b0;
        any_touch = 1'b0;
        for (int p = 0; p < PLANES; p++) begin
            any_out   = any_out | flags[p].outside;
            any_touch = any_touch | flags[p].touch;
        end
        if (any_out) begin
            n_verdict = VERDICT_OUTSIDE;
        end else if (any_touch) begin
            n_verdict = VERDICT_INTERSECTS;
        end else begin
            n_verdict = VERDICT_INSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (stage_en.s1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (stage_en.s2) begin
                r_v2 <= r_v1;
            end
            if (stage_en.s3) begin
                r_v3 <= r_v2;
            end
            if (out_ready) begin
                r_out_valid <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            r_verdict <= n_verdict;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-2){1'b0}}, r_verdict};

endmodule

// ----- design/fac_checker.sv -----
`include "frustum_aabb_cull_defines.svh"

module fac_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [fac_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import fac_pkg::*;

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // A held result keeps its value until it is taken.
    `FAC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled verdict changed")

    // With nothing waiting at the output, the whole pipeline can move.
    `FAC_ASSERT_NOW(a_ready_free, !m_axis_tvalid || m_axis_tready, s_axis_tready,
        "input refused while output side is free")

    // With the output always taken, every accepted request shows up as a well-formed verdict.
    `FAC_ASSERT_NOW(a_latency,
        $past(in_acc, 4) && $past(m_axis_tready, 1) && $past(m_axis_tready, 2) &&
        $past(m_axis_tready, 3) && $past(i_rst_n, 1) && $past(i_rst_n, 2) &&
        $past(i_rst_n, 3) && $past(i_rst_n, 4),
        m_axis_tvalid && ((m_axis_tdata == OUT_TDATA_W'(VERDICT_OUTSIDE)) ||
        (m_axis_tdata == OUT_TDATA_W'(VERDICT_INTERSECTS)) ||
        (m_axis_tdata == OUT_TDATA_W'(VERDICT_INSIDE))),
        "verdict missing or malformed after a free-flowing request")

endmodule

bind frustum_aabb_cull fac_checker u_fac_checker (.*);

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import fac_pkg::*;

    // The verdict register is the fourth stage after the request is taken.
    localparam int PIPE_LATENCY = 4;
    localparam int HOLD_CYCLES  = 400;
    localparam int PLAN_COUNT   = 9;
    localparam int QUIET_PLAN   = 6;
    localparam int DIRECTED_ROWS = 15;

    localparam t_dist DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam t_dist DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};
    localparam t_ncomp NCOMP_MAX = {1'b0, {(NORMAL_W-1){1'b1}}};
    localparam t_ncomp NCOMP_MIN = {1'b1, {(NORMAL_W-1){1'b0}}};
    localparam t_ncomp NCOMP_ZERO = '0;

    // Plane settings that the run steps through.
    typedef enum logic [2:0] {
        SET_RESET,
        SET_MAX,
        SET_MIN,
        SET_MIXED,
        SET_ZERO,
        SET_RANDOM
    } t_plane_set;

    // One row of the directed table. When typed is set, verdict holds the answer
    // that can be read straight off the plane equations; otherwise the predictor
    // supplies it.
    typedef struct packed {
        t_box     box;
        logic     typed;
        t_verdict verdict;
    } t_box_case;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                   i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // Fields from bit 0 up: min_x, min_y, min_z, max_x, max_y, max_z.
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;

    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // Fields from bit 0 up: verdict (2 bits), then zero fill.
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // The testbench's own copy of the plane registers, kept in step with every
    // write that goes to the block.
    t_normal plane_normal[PLANES];
    t_dist   plane_dist[PLANES];

    // Verdicts still owed by the block, oldest first.
    t_verdict expected_verdicts[$];

    int unsigned fail_count      = 0;
    int unsigned boxes_sent      = 0;
    int unsigned verdicts_seen   = 0;
    int unsigned settings_used   = 0;
    int unsigned verdict_tally[3] = '{0, 0, 0};

    // Flow control modes shared with the receiver process.
    logic        quiet_phase = 1'b0;
    logic        hold_armed  = 1'b0;
    logic        hold_done   = 1'b0;
    int unsigned hold_count  = 0;

    t_box_case   directed_cases[DIRECTED_ROWS];
    t_plane_set  plan_kind[PLAN_COUNT];
    int unsigned plan_items[PLAN_COUNT];

    frustum_aabb_cull u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expected verdict of one box under the current planes. For each plane the
    // corner reached along the normal gives the largest signed distance and the
    // opposite corner the smallest. The largest below zero puts the box outside
    // that plane; the smallest at or below zero means the plane cuts the box.
    // Outside on any plane wins over everything else.
    function automatic t_verdict predict_verdict(input t_box box);
        longint   reach_sum;
        longint   least_sum;
        longint   ncomp;
        longint   lo_bound;
        longint   hi_bound;
        t_verdict verdict;
        verdict = VERDICT_INSIDE;
        for (int p = 0; p < PLANES; p++) begin
            reach_sum = plane_dist[p];
            least_sum = plane_dist[p];
            for (int a = 0; a < AXES; a++) begin
                ncomp    = t_ncomp'(plane_normal[p][a*NORMAL_W +: NORMAL_W]);
                lo_bound = $signed(box.lo[a]);
                hi_bound = $signed(box.hi[a]);
                // A zero component takes the min bound; its product vanishes anyway.
                if (ncomp > 0) begin
                    reach_sum += ncomp * hi_bound;
                    least_sum += ncomp * lo_bound;
                end else begin
                    reach_sum += ncomp * lo_bound;
                    least_sum += ncomp * hi_bound;
                end
            end
            if (reach_sum < 0) begin
                verdict = VERDICT_OUTSIDE;
            end else if (least_sum <= 0 && verdict != VERDICT_OUTSIDE) begin
                verdict = VERDICT_INTERSECTS;
            end
        end
        return verdict;
    endfunction

    function automatic t_box make_box(input int min_x, input int min_y, input int min_z,
                                      input int max_x, input int max_y, input int max_z);
        t_box box;
        box.lo[0] = t_coord'(min_x);
        box.lo[1] = t_coord'(min_y);
        box.lo[2] = t_coord'(min_z);
        box.hi[0] = t_coord'(max_x);
        box.hi[1] = t_coord'(max_y);
        box.hi[2] = t_coord'(max_z);
        return box;
    endfunction

    // Most boxes are well formed: a center in the middle of the space with a
    // modest extent, so that all three verdicts come up. One in five has raw
    // random corners, which toggles every coordinate bit, and a few have their
    // corners swapped so that min stands above max.
    function automatic t_box random_box();
        t_box        box;
        t_coord      swap;
        int          center;
        int          extent;
        int unsigned shape;
        shape = $urandom_range(99);
        for (int a = 0; a < AXES; a++) begin
            if (shape < 20) begin
                box.lo[a] = t_coord'($urandom);
                box.hi[a] = t_coord'($urandom);
            end else begin
                center    = int'($urandom_range(0, 2**21)) - 2**20;
                extent    = int'($urandom_range(0, 2**18));
                box.lo[a] = t_coord'(center - extent);
                box.hi[a] = t_coord'(center + extent);
            end
            if (shape >= 95) begin
                swap      = box.lo[a];
                box.lo[a] = box.hi[a];
                box.hi[a] = swap;
            end
        end
        return box;
    endfunction

    // Loads the local copy of the planes for one setting. The caller then
    // pushes the copy into the block.
    function automatic void choose_planes(input t_plane_set kind);
        logic [63:0] raw;
        for (int p = 0; p < PLANES; p++) begin
            case (kind)
                SET_MAX: begin
                    plane_normal[p] = {NCOMP_MAX, NCOMP_MAX, NCOMP_MAX};
                    plane_dist[p]   = (p == PLANES - 1) ? DIST_MAX : '0;
                end
                SET_MIN: begin
                    plane_normal[p] = {NCOMP_MIN, NCOMP_MIN, NCOMP_MIN};
                    plane_dist[p]   = (p == 0) ? DIST_MIN : '0;
                end
                SET_MIXED: begin
                    case (p)
                        0: begin
                            plane_normal[p] = {NCOMP_ZERO, NCOMP_MAX, NCOMP_MIN};
                            plane_dist[p]   = DIST_MAX;
                        end
                        1: begin
                            plane_normal[p] = {NCOMP_MIN, NCOMP_ZERO, NCOMP_MAX};
                            plane_dist[p]   = DIST_MIN;
                        end
                        2: begin
                            plane_normal[p] = {NCOMP_MAX, NCOMP_MIN, NCOMP_ZERO};
                            plane_dist[p]   = t_dist'(1);
                        end
                        default: begin
                            plane_normal[p] = {NCOMP_MAX, NCOMP_MAX, NCOMP_MIN};
                            plane_dist[p]   = t_dist'(-1);
                        end
                    endcase
                end
                SET_ZERO: begin
                    plane_normal[p] = '0;
                    plane_dist[p]   = '0;
                end
                SET_RANDOM: begin
                    raw             = {$urandom, $urandom};
                    plane_normal[p] = raw[NORMAL_PK_W-1:0];
                    raw             = {$urandom, $urandom};
                    // Scale the offset so it competes with the dot products.
                    plane_dist[p]   = $signed(raw[DIST_W-1:0]) >>> $urandom_range(6, 16);
                end
                default: begin
                end
            endcase
        end
    endfunction

    // Writes all eight registers from the local copy, one per cycle. The unused
    // top bits of a normal write carry random junk that the block must drop.
    task automatic write_planes();
        logic [CFG_DATA_W-1:0] word;
        for (int p = 0; p < PLANES; p++) begin
            word                    = CFG_DATA_W'({$urandom, $urandom});
            word[NORMAL_PK_W-1:0]   = plane_normal[p];
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(CFG_LEFT_NORMAL + p);
            i_cfg_data <= word;
            @(posedge i_clk);
        end
        for (int p = 0; p < PLANES; p++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(CFG_LEFT_DISTANCE + p);
            i_cfg_data <= plane_dist[p];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Offers one box request, with a random gap in front unless the phase is a
    // quiet one, and records the verdict it owes once the block takes it.
    task automatic send_box(input t_box box, input t_verdict verdict);
        while (!quiet_phase && $urandom_range(99) < 12) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= box;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_verdicts.push_back(verdict);
        boxes_sent++;
    endtask

    // Stops offering requests and waits until the pipeline has drained, so that
    // the planes can be rewritten safely.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    // Receiver. It is ready about 88 percent of the time, never idles in
    // the quiet phase, and once holds off for a long stretch so that the whole
    // pipeline backs up and the block refuses new box requests.
    always @(posedge i_clk) begin
        if (hold_armed && !hold_done) begin
            if (hold_count < HOLD_CYCLES) begin
                m_axis_tready <= 1'b0;
                hold_count    <= hold_count + 1;
            end else begin
                hold_done <= 1'b1;
            end
        end else if (quiet_phase) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= 12);
        end
    end

    // Checker. Every verdict the block hands over is matched against the oldest
    // one still owed; the zero fill above the verdict is checked as well.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            verdicts_seen++;
            if (m_axis_tdata[1:0] < 2'd3) begin
                verdict_tally[m_axis_tdata[1:0]]++;
            end
            if (expected_verdicts.size() == 0) begin
                $error("verdict: none expected, got %0d", m_axis_tdata[1:0]);
                fail_count++;
            end else begin
                if (m_axis_tdata[1:0] !== expected_verdicts[0]) begin
                    $error("verdict: expected %0d, got %0d",
                           expected_verdicts[0], m_axis_tdata[1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[OUT_TDATA_W-1:2] !== '0) begin
                    $error("fill: expected 0, got %0h", m_axis_tdata[OUT_TDATA_W-1:2]);
                    fail_count++;
                end
                void'(expected_verdicts.pop_front());
            end
        end
    end

    // Main sequence: reset, the directed table under the default planes, then a
    // series of plane settings each followed by a stream of random boxes.
    initial begin
        t_box box;

        plane_normal[0] = LEFT_NORMAL_RST;
        plane_normal[1] = RIGHT_NORMAL_RST;
        plane_normal[2] = TOP_NORMAL_RST;
        plane_normal[3] = BOTTOM_NORMAL_RST;
        for (int p = 0; p < PLANES; p++) plane_dist[p] = '0;

        // With the default planes a box right at the origin touches all four
        // planes, the widest box straddles them, a small box well ahead is
        // inside and the same box behind the eye is outside.
        directed_cases[0]  = '{make_box(0, 0, 0, 0, 0, 0), 1'b1, VERDICT_INTERSECTS};
        directed_cases[1]  = '{make_box(-8388608, -8388608, -8388608,
                                        8388607, 8388607, 8388607), 1'b1, VERDICT_INTERSECTS};
        directed_cases[2]  = '{make_box(-10, -10, 1000, 10, 10, 2000), 1'b1, VERDICT_INSIDE};
        directed_cases[3]  = '{make_box(-10, -10, -2000, 10, 10, -1000), 1'b1, VERDICT_OUTSIDE};
        directed_cases[4]  = '{make_box(8388607, 8388607, 8388607,
                                        8388607, 8388607, 8388607), 1'b0, VERDICT_INSIDE};
        directed_cases[5]  = '{make_box(-8388608, -8388608, -8388608,
                                        -8388608, -8388608, -8388608), 1'b0, VERDICT_INSIDE};
        // Corners given the wrong way round are used as they stand.
        directed_cases[6]  = '{make_box(10, 10, 2000, -10, -10, 1000), 1'b0, VERDICT_INSIDE};
        directed_cases[7]  = '{make_box(8388607, 8388607, 8388607,
                                        -8388608, -8388608, -8388608), 1'b0, VERDICT_INSIDE};
        directed_cases[8]  = '{make_box(-5000, -10, 1000, -3000, 10, 1100), 1'b0, VERDICT_INSIDE};
        directed_cases[9]  = '{make_box(-8388608, 0, 0, -8000000, 0, 10), 1'b0, VERDICT_INSIDE};
        directed_cases[10] = '{make_box(0, 8000000, 0, 10, 8388607, 100), 1'b0, VERDICT_INSIDE};
        directed_cases[11] = '{make_box(0, -8388608, 0, 10, -8000000, 100), 1'b0, VERDICT_INSIDE};
        directed_cases[12] = '{make_box(8000000, 0, 0, 8388607, 10, 100), 1'b0, VERDICT_INSIDE};
        directed_cases[13] = '{make_box(8388607, -8388608, 0, -8388608, 8388607, 0),
                               1'b0, VERDICT_INSIDE};
        directed_cases[14] = '{make_box(-1, -1, -1, -1, -1, -1), 1'b0, VERDICT_INSIDE};

        plan_kind  = '{SET_RESET, SET_MAX, SET_MIN, SET_MIXED, SET_ZERO,
                       SET_RANDOM, SET_RANDOM, SET_RANDOM, SET_RANDOM};
        plan_items = '{250, 80, 80, 80, 60, 270, 270, 270, 270};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int plan = 0; plan < PLAN_COUNT; plan++) begin
            if (plan_kind[plan] != SET_RESET) begin
                wait_idle();
                choose_planes(plan_kind[plan]);
                write_planes();
            end
            settings_used++;
            quiet_phase <= (plan == QUIET_PLAN);
            if (plan == 0) begin
                foreach (directed_cases[row]) begin
                    send_box(directed_cases[row].box,
                             directed_cases[row].typed ? directed_cases[row].verdict
                                                       : predict_verdict(directed_cases[row].box));
                end
                // The long receiver hold-off starts during the first random stream.
                hold_armed <= 1'b1;
            end
            repeat (plan_items[plan]) begin
                box = random_box();
                send_box(box, predict_verdict(box));
            end
        end

        wait_idle();
        $display("Sent %0d boxes under %0d plane settings, %0d verdicts checked.",
                 boxes_sent, settings_used, verdicts_seen);
        $display("Verdicts seen: %0d outside, %0d intersecting, %0d inside.",
                 verdict_tally[0], verdict_tally[1], verdict_tally[2]);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- frustum_aabb_cull.f -----
+incdir+design
design/fac_pkg.sv
design/fac_plane.sv
design/frustum_aabb_cull.sv
design/fac_checker.sv
sim/testbench.sv
